/* sv/tfa_pkg.sv */
package tfa_pkg;

  // Result status codes.
  localparam logic [3:0] ST_OK          = 4'd0;
  localparam logic [3:0] ST_VERSION     = 4'd1;
  localparam logic [3:0] ST_VCID        = 4'd2;
  localparam logic [3:0] ST_KIND        = 4'd3;
  localparam logic [3:0] ST_LOCKED      = 4'd4;
  localparam logic [3:0] ST_SEGMENT     = 4'd5;
  localparam logic [3:0] ST_PKT_VERSION = 4'd6;
  localparam logic [3:0] ST_PKT_SECHDR  = 4'd7;
  localparam logic [3:0] ST_PKT_TYPE    = 4'd8;
  localparam logic [3:0] ST_PKT_APID    = 4'd9;
  localparam logic [3:0] ST_PKT_SEQFLAG = 4'd10;
  localparam logic [3:0] ST_POSITIVE    = 4'd11;
  localparam logic [3:0] ST_NEGATIVE    = 4'd12;
  localparam logic [3:0] ST_LOCKOUT     = 4'd13;
  localparam logic [3:0] ST_BAD_CONTROL = 4'd14;

  // Frame kinds (bypass and control flag bits).
  localparam logic [1:0] KIND_AD = 2'd0;
  localparam logic [1:0] KIND_BD = 2'd2;
  localparam logic [1:0] KIND_BC = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] REG_VCID       = 3'd0;
  localparam logic [2:0] REG_APID_FIRST = 3'd1;
  localparam logic [2:0] REG_APID_SECOND = 3'd2;
  localparam logic [2:0] REG_APID_THIRD = 3'd3;
  localparam logic [2:0] REG_POS_WINDOW = 3'd4;

  localparam int unsigned CfgIndexWidth = 3;
  localparam int unsigned CfgDataWidth  = 11;

  localparam logic [6:0]  POS_WINDOW_RESET = 7'd64;
  localparam logic [1:0]  FLAG_UNSEGMENTED = 2'd3;
  localparam logic [1:0]  FLAG_STANDALONE  = 2'd3;
  localparam logic [7:0]  BC_UNLOCK_B0     = 8'h00;
  localparam logic [7:0]  BC_SETVR_B0      = 8'h82;
  localparam logic [7:0]  BC_SETVR_B1      = 8'h00;
  localparam logic [10:0] BC_UNLOCK_LEN    = 11'd8;
  localparam logic [10:0] BC_SETVR_LEN     = 11'd10;
  localparam logic [31:0] CLCW_COP1        = 32'h0100_0000;

  typedef struct packed {
    logic [1:0]  frame_version;
    logic [5:0]  vcid;
    logic [1:0]  frame_kind;
    logic [7:0]  frame_seq;
    logic [10:0] frame_octets;
    logic [1:0]  segment_seq_flag;
    logic [15:0] packet_id;
    logic [1:0]  packet_seq_flag;
    logic [23:0] control_bytes;
  } tfa_frame_t;

  typedef struct packed {
    logic [5:0]  accepted_vcid;
    logic [10:0] apid_first;
    logic [10:0] apid_second;
    logic [10:0] apid_third;
    logic [6:0]  positive_window;
  } tfa_cfg_t;

  typedef struct packed {
    logic [7:0] expected_seq;
    logic       locked_out;
    logic       retransmit_wanted;
    logic [1:0] bypass_count;
  } tfa_state_t;

endpackage

/* sv/tfa_eval.sv */
module tfa_eval import tfa_pkg::*; (
  input  tfa_frame_t frame_i,
  input  tfa_cfg_t   cfg_i,
  input  tfa_state_t state_i,
  output tfa_state_t state_o,
  output logic [3:0] status_o
);

  logic [3:0]  hdr_status;
  logic [10:0] apid;
  logic [7:0]  seq_delta;
  logic [8:0]  neg_sum;
  logic        in_negative;
  logic [7:0]  b0, b1, b2;

  assign apid = frame_i.packet_id[10:0];
  assign seq_delta = frame_i.frame_seq - state_i.expected_seq;
  // The distance lies in the negative window when d + W reaches the modulus.
  assign neg_sum = {1'b0, seq_delta} + {2'b00, cfg_i.positive_window};
  assign in_negative = neg_sum[8];
  assign b0 = frame_i.control_bytes[23:16];
  assign b1 = frame_i.control_bytes[15:8];
  assign b2 = frame_i.control_bytes[7:0];

  // Segment and packet header checks shared by AD and BD frames.
  always_comb begin
    if (frame_i.segment_seq_flag != FLAG_UNSEGMENTED) begin
      hdr_status = ST_SEGMENT;
    end else if (frame_i.packet_id[15:13] != 3'd0) begin
      hdr_status = ST_PKT_VERSION;
    end else if (!frame_i.packet_id[11]) begin
      hdr_status = ST_PKT_SECHDR;
    end else if (!frame_i.packet_id[12]) begin
      hdr_status = ST_PKT_TYPE;
    end else if (!(apid == cfg_i.apid_first || apid == cfg_i.apid_second ||
                   apid == cfg_i.apid_third)) begin
      hdr_status = ST_PKT_APID;
    end else if (frame_i.packet_seq_flag != FLAG_STANDALONE) begin
      hdr_status = ST_PKT_SEQFLAG;
    end else begin
      hdr_status = ST_OK;
    end
  end

  always_comb begin
    state_o  = state_i;
    status_o = ST_OK;
    if (frame_i.frame_version != 2'd0) begin
      status_o = ST_VERSION;
    end else if (frame_i.vcid != cfg_i.accepted_vcid) begin
      status_o = ST_VCID;
    end else begin
      case (frame_i.frame_kind)
        KIND_AD: begin
          if (state_i.locked_out) begin
            status_o = ST_LOCKED;
          end else if (hdr_status != ST_OK) begin
            status_o = hdr_status;
          end else if (seq_delta == 8'd0) begin
            state_o.retransmit_wanted = 1'b0;
            state_o.expected_seq      = state_i.expected_seq + 8'd1;
          end else if (seq_delta <= {1'b0, cfg_i.positive_window}) begin
            state_o.retransmit_wanted = 1'b1;
            status_o = ST_POSITIVE;
          end else if (in_negative) begin
            status_o = ST_NEGATIVE;
          end else begin
            state_o.locked_out = 1'b1;
            status_o = ST_LOCKOUT;
          end
        end
        KIND_BD: begin
          status_o = hdr_status;
          if (hdr_status == ST_OK) begin
            state_o.bypass_count = state_i.bypass_count + 2'd1;
          end
        end
        KIND_BC: begin
          if (b0 == BC_UNLOCK_B0 && frame_i.frame_octets == BC_UNLOCK_LEN) begin
            state_o.locked_out        = 1'b0;
            state_o.retransmit_wanted = 1'b0;
            state_o.bypass_count      = state_i.bypass_count + 2'd1;
          end else if (b0 == BC_SETVR_B0 && b1 == BC_SETVR_B1 &&
                       frame_i.frame_octets == BC_SETVR_LEN) begin
            if (!state_i.locked_out) begin
              state_o.expected_seq      = b2;
              state_o.retransmit_wanted = 1'b0;
            end
            state_o.bypass_count = state_i.bypass_count + 2'd1;
          end else begin
            status_o = ST_BAD_CONTROL;
          end
        end
        default: begin
          status_o = ST_KIND;
        end
      endcase
    end
  end

endmodule

/* sv/telecommand_frame_acceptance_unit.sv */
// Telecommand frame acceptance unit (receiver side of COP-1 sequence control).
// The slave stream carries one parsed frame per item; the frame kind travels
// in s_axis_tuser, the remaining header fields in s_axis_tdata. Each item
// yields exactly one master item with a status code and the control word
// (CLCW) as it stands after that frame has been handled.
// An item is registered on acceptance, evaluated in the following cycle
// against the configuration and the sequence state, and the result is
// registered once the result register is free; one item can be taken every
// cycle while the receiver takes results. The throughput is set by the
// single evaluation stage, which reads and updates the sequence state in the
// same cycle.
// When the receiver stalls, the result register holds its item and the input
// register fills; further items are refused only when both are full.
// Reset clears the sequence state (expected number, lockout, retransmit flag,
// bypass count), empties both stages, and loads the configuration defaults:
// channel and APIDs zero, positive window 64. Configuration is written
// through cfg_we_i, cfg_index_i and cfg_data_i while no item is in flight.
module telecommand_frame_acceptance_unit import tfa_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CfgIndexWidth-1:0] cfg_index_i,
  input  logic [CfgDataWidth-1:0]  cfg_data_i,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // tdata from bit 0: frame_version[1:0], vcid[7:2], frame_seq[15:8],
  // frame_octets[26:16], segment_seq_flag[28:27], packet_id[44:29],
  // packet_seq_flag[46:45], control_bytes[70:47], zero fill[71]
  input  logic [71:0]              s_axis_tdata,
  // tuser: frame_kind[1:0]
  input  logic [1:0]               s_axis_tuser,
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // tdata from bit 0: status[3:0], control_word[35:4], zero fill[39:36]
  output logic [39:0]              m_axis_tdata
);

  tfa_cfg_t   cfg_q;
  tfa_state_t state_q, state_d;
  tfa_frame_t frame_q, frame_in;
  logic       in_valid_q;
  logic       out_valid_q;
  logic [3:0] status_d, status_q;
  logic [31:0] clcw_d, clcw_q;
  logic       advance;

  assign frame_in.frame_version    = s_axis_tdata[1:0];
  assign frame_in.vcid             = s_axis_tdata[7:2];
  assign frame_in.frame_kind       = s_axis_tuser;
  assign frame_in.frame_seq        = s_axis_tdata[15:8];
  assign frame_in.frame_octets     = s_axis_tdata[26:16];
  assign frame_in.segment_seq_flag = s_axis_tdata[28:27];
  assign frame_in.packet_id        = s_axis_tdata[44:29];
  assign frame_in.packet_seq_flag  = s_axis_tdata[46:45];
  assign frame_in.control_bytes    = s_axis_tdata[70:47];

  // The evaluation stage moves forward when the result register is free.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.accepted_vcid   <= '0;
      cfg_q.apid_first      <= '0;
      cfg_q.apid_second     <= '0;
      cfg_q.apid_third      <= '0;
      cfg_q.positive_window <= POS_WINDOW_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_VCID:        cfg_q.accepted_vcid   <= cfg_data_i[5:0];
        REG_APID_FIRST:  cfg_q.apid_first      <= cfg_data_i[10:0];
        REG_APID_SECOND: cfg_q.apid_second     <= cfg_data_i[10:0];
        REG_APID_THIRD:  cfg_q.apid_third      <= cfg_data_i[10:0];
        REG_POS_WINDOW:  cfg_q.positive_window <= cfg_data_i[6:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      frame_q <= frame_in;
    end
  end

  tfa_eval u_eval (
    .frame_i  (frame_q),
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .state_o  (state_d),
    .status_o (status_d)
  );

  assign clcw_d = CLCW_COP1
                | {18'd0, state_d.locked_out, 13'd0}
                | {20'd0, state_d.retransmit_wanted, 11'd0}
                | {21'd0, state_d.bypass_count, 9'd0}
                | {24'd0, state_d.expected_seq};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        state_q     <= state_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      status_q <= status_d;
      clcw_q   <= clcw_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, clcw_q, status_q};

endmodule
